/* rtl/core/lzfd_pkg.sv */
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared types and constants of the flag-byte lz77 decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;

   localparam int unsigned LZFD_WIN_AW   = 12;
   localparam int unsigned LZFD_LEN_W    = 24;
   localparam int unsigned LZFD_CNT_W    = 5;
   localparam logic [LZFD_CNT_W-1:0] LZFD_MIN_MATCH = 5'd3;
   localparam logic [3:0] LZFD_GROUP_TOKENS = 4'd8;

   // window access issued by the sequencer
   typedef struct packed {
      logic                   we;
      logic [LZFD_WIN_AW-1:0] waddr;
      logic [7:0]             wdata;
      logic                   re;
      logic [LZFD_WIN_AW-1:0] raddr;
   } win_req_type;

   // one result loaded into the output register
   typedef struct packed {
      logic       load;
      logic [7:0] data;
      logic       last;
      logic       stream_end;
   } out_load_type;

endpackage

/* rtl/core/lz77_flag_byte_decompressor_top.sv */
// ----------------------------------------------------------------------------
// lz77_flag_byte_decompressor_top
// Flag-byte lz77 decompressor taking one compressed byte per transfer.
// ----------------------------------------------------------------------------
// After reset the 4096-byte history window is swept to zero, one entry a
// cycle, and req_tready stays low until the sweep is done. Header, flag and
// first pair bytes are taken in the idle state. A literal is accepted, then
// written to the window and emitted. A match accepts its second byte, then
// copies 3 to 18 bytes (fewer if the stated length is reached), each through
// a read state and a copy state, because every copied byte needs its own
// registered read of the window, which must land before the byte is written
// back and the next read issued. An emit step waits while the output register
// is full and not being taken. rsp_tlast marks the last byte of one token,
// rsp_tuser the byte that reaches the stated length; the window is kept across streams.
module lz77_flag_byte_decompressor_top
   import lzfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] stream_end
);

   win_req_type  win_req;
   out_load_type out_load;
   logic [7:0]   win_rd_data;
   logic         win_busy;
   logic         slot_free;

   lzfd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .win_req (win_req),
      .rd_data (win_rd_data),
      .busy    (win_busy)
   );

   lzfd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .win_busy    (win_busy),
      .win_rd_data (win_rd_data),
      .win_req     (win_req),
      .slot_free   (slot_free),
      .out_load    (out_load)
   );

   lzfd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .out_load   (out_load),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/core/lzfd_window.sv */
// ----------------------------------------------------------------------------
// lzfd_window
// 4096-byte history window, registered read, zero sweep after reset.
// ----------------------------------------------------------------------------
module lzfd_window
   import lzfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  win_req_type win_req,
   output logic [7:0]  rd_data,
   output logic        busy
);

   localparam int unsigned Depth = 1 << LZFD_WIN_AW;

   logic [7:0]             mem [Depth];
   logic [7:0]             rd_data_ff;
   logic                   clearing_ff;
   logic [LZFD_WIN_AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {LZFD_WIN_AW{1'b1}}) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (win_req.we) begin
         mem[win_req.waddr] <= win_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (win_req.re) begin
         rd_data_ff <= mem[win_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

/* rtl/core/lzfd_out_stage.sv */
// ----------------------------------------------------------------------------
// lzfd_out_stage
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module lzfd_out_stage
   import lzfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  out_load_type out_load,
   output logic         slot_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tuser
);

   logic       valid_ff;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_load.load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load.load) begin
         data_ff <= out_load.data;
         last_ff <= out_load.last;
         end_ff  <= out_load.stream_end;
      end
   end

   assign slot_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = end_ff;

endmodule

/* rtl/core/lzfd_seq.sv */
// ----------------------------------------------------------------------------
// lzfd_seq
// Stream parser and copy sequencer; one window access per step.
// ----------------------------------------------------------------------------
module lzfd_seq
   import lzfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         win_busy,
   input  logic [7:0]   win_rd_data,
   output win_req_type  win_req,
   input  logic         slot_free,
   output out_load_type out_load
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LIT,
      S_RD,
      S_CP
   } state_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_FLAG,
      PH_TOKEN,
      PH_PAIRLO
   } phase_type;

   state_type              state_ff,   state_in;
   phase_type              phase_ff,   phase_in;
   logic [1:0]             hdr_idx_ff, hdr_idx_in;
   logic [LZFD_LEN_W-1:0]  target_ff,  target_in;
   logic [LZFD_LEN_W-1:0]  produced_ff, produced_in;
   logic [LZFD_WIN_AW-1:0] wpos_ff,    wpos_in;
   logic [7:0]             flags_ff,   flags_in;
   logic [3:0]             left_ff,    left_in;
   logic [7:0]             pair_ff,    pair_in;
   logic [LZFD_WIN_AW-1:0] dist_ff,    dist_in;
   logic [LZFD_CNT_W-1:0]  cnt_ff,     cnt_in;
   logic [7:0]             lit_ff,     lit_in;

   logic [LZFD_LEN_W-1:0]  prod_inc;
   logic                   hit_len;
   logic                   tok_done;
   logic                   tok_end;
   logic                   accept;
   logic [3:0]             left_dec;

   assign accept   = req_tvalid && req_tready;
   assign prod_inc = produced_ff + 1'b1;
   assign hit_len  = prod_inc == target_ff;
   assign left_dec = left_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      target_in   = target_ff;
      produced_in = produced_ff;
      wpos_in     = wpos_ff;
      flags_in    = flags_ff;
      left_in     = left_ff;
      pair_in     = pair_ff;
      dist_in     = dist_ff;
      cnt_in      = cnt_ff;
      lit_in      = lit_ff;
      tok_done    = 1'b0;
      tok_end     = 1'b0;

      win_req.we    = 1'b0;
      win_req.waddr = wpos_ff;
      win_req.wdata = lit_ff;
      win_req.re    = 1'b0;
      win_req.raddr = wpos_ff - dist_ff - 1'b1;

      out_load.load       = 1'b0;
      out_load.data       = lit_ff;
      out_load.last       = 1'b1;
      out_load.stream_end = hit_len;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_FLAG: begin
                     flags_in = req_tdata;
                     left_in  = LZFD_GROUP_TOKENS;
                     phase_in = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (!flags_ff[7]) begin
                        lit_in   = req_tdata;
                        state_in = S_LIT;
                     end else begin
                        pair_in  = req_tdata;
                        phase_in = PH_PAIRLO;
                     end
                  end
                  PH_PAIRLO: begin
                     dist_in  = {pair_ff[3:0], req_tdata};
                     cnt_in   = {1'b0, pair_ff[7:4]} + LZFD_MIN_MATCH;
                     state_in = S_RD;
                  end
                  default: begin
                     case (hdr_idx_ff)
                        2'd0: hdr_idx_in = 2'd1;
                        2'd1: begin
                           target_in  = {16'h0000, req_tdata};
                           hdr_idx_in = 2'd2;
                        end
                        2'd2: begin
                           target_in  = {8'h00, req_tdata, target_ff[7:0]};
                           hdr_idx_in = 2'd3;
                        end
                        default: begin
                           target_in   = {req_tdata, target_ff[15:0]};
                           hdr_idx_in  = 2'd0;
                           produced_in = '0;
                           left_in     = '0;
                           flags_in    = '0;
                           // zero length goes straight back to the header
                           phase_in    = ({req_tdata, target_ff[15:0]} == '0) ?
                                         PH_HEADER : PH_FLAG;
                        end
                     endcase
                  end
               endcase
            end
         end
         S_LIT: begin
            if (slot_free) begin
               win_req.we    = 1'b1;
               out_load.load = 1'b1;
               wpos_in       = wpos_ff + 1'b1;
               produced_in   = prod_inc;
               tok_done      = 1'b1;
               tok_end       = hit_len;
               state_in      = S_IDLE;
            end
         end
         S_RD: begin
            win_req.re = 1'b1;
            state_in   = S_CP;
         end
         S_CP: begin
            win_req.wdata = win_rd_data;
            out_load.data = win_rd_data;
            out_load.last = hit_len || (cnt_ff == 5'd1);
            if (slot_free) begin
               win_req.we    = 1'b1;
               out_load.load = 1'b1;
               wpos_in       = wpos_ff + 1'b1;
               produced_in   = prod_inc;
               cnt_in        = cnt_ff - 1'b1;
               if (hit_len || (cnt_ff == 5'd1)) begin
                  tok_done = 1'b1;
                  tok_end  = hit_len;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (tok_done) begin
         if (tok_end) begin
            // stated length reached: drop the rest of the group
            phase_in   = PH_HEADER;
            hdr_idx_in = 2'd0;
            left_in    = '0;
            flags_in   = '0;
         end else begin
            flags_in = {flags_ff[6:0], 1'b0};
            left_in  = left_dec;
            phase_in = (left_dec == '0) ? PH_FLAG : PH_TOKEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_HEADER;
         hdr_idx_ff  <= '0;
         target_ff   <= '0;
         produced_ff <= '0;
         wpos_ff     <= '0;
         flags_ff    <= '0;
         left_ff     <= '0;
         pair_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         target_ff   <= target_in;
         produced_ff <= produced_in;
         wpos_ff     <= wpos_in;
         flags_ff    <= flags_in;
         left_ff     <= left_in;
         pair_ff     <= pair_in;
      end
      dist_ff <= dist_in;
      cnt_ff  <= cnt_in;
      lit_ff  <= lit_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !win_busy;

endmodule
